@@ src/cbp_pkg.sv @@
// Shared types and constants of the chunked body parser.
package cbp_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_LEN     = 4'b0001,
    PH_LEN_LF  = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_DATA_LF = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  // Control state carried from item to item.
  typedef struct packed {
    phase_e phase;
    logic   have_digit;
  } ctl_t;

  // One result item.
  typedef struct packed {
    status_e    status;
    logic       data_valid;
    logic [7:0] out_byte;
  } result_t;

endpackage

@@ src/cbp_step.sv @@
// Next-state and result logic for one body byte.
module cbp_step #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic [7:0]              byte_i,
  input  logic                    restart_i,
  input  cbp_pkg::ctl_t           ctl_i,
  input  logic [LENGTH_WIDTH-1:0] len_accum_i,
  input  logic [LENGTH_WIDTH-1:0] chunk_size_i,
  input  logic [LENGTH_WIDTH-1:0] bytes_seen_i,
  output cbp_pkg::ctl_t           ctl_o,
  output logic [LENGTH_WIDTH-1:0] len_accum_o,
  output logic [LENGTH_WIDTH-1:0] chunk_size_o,
  output logic [LENGTH_WIDTH-1:0] bytes_seen_o,
  output cbp_pkg::result_t        result_o
);

  localparam int unsigned WideWidth = LENGTH_WIDTH + 4;

  logic                    is_digit;
  logic [3:0]              digit;
  logic [WideWidth-1:0]    wide_acc;
  logic [WideWidth-1:0]    acc_x10;
  logic                    overflow;
  logic                    take;
  logic [LENGTH_WIDTH-1:0] seen_inc;

  assign is_digit = (byte_i >= cbp_pkg::DIGIT_0) && (byte_i <= cbp_pkg::DIGIT_9);
  assign digit    = 4'(byte_i - cbp_pkg::DIGIT_0);

  // Ten times the length plus the digit, four bits wider so that a carry past
  // the length width flags an overflow.
  assign wide_acc = {4'b0, len_accum_i};
  assign acc_x10  = (wide_acc << 3) + (wide_acc << 1) + {{LENGTH_WIDTH{1'b0}}, digit};
  assign overflow = |acc_x10[WideWidth-1:LENGTH_WIDTH];

  assign take     = bytes_seen_i < chunk_size_i;
  assign seen_inc = (&bytes_seen_i) ? bytes_seen_i : bytes_seen_i + 1'b1;

  always_comb begin
    ctl_o        = ctl_i;
    len_accum_o  = len_accum_i;
    chunk_size_o = chunk_size_i;
    bytes_seen_o = bytes_seen_i;
    result_o.status     = cbp_pkg::ST_PENDING;
    result_o.data_valid = 1'b0;
    result_o.out_byte   = 8'h00;

    if (restart_i) begin
      ctl_o.phase      = cbp_pkg::PH_LEN;
      ctl_o.have_digit = 1'b0;
      len_accum_o      = '0;
      chunk_size_o     = '0;
      bytes_seen_o     = '0;
    end else begin
      case (ctl_i.phase)
        cbp_pkg::PH_LEN: begin
          if (is_digit) begin
            if (overflow) begin
              result_o.status = cbp_pkg::ST_BAD;
            end else begin
              len_accum_o      = acc_x10[LENGTH_WIDTH-1:0];
              ctl_o.have_digit = 1'b1;
            end
          end else if (byte_i == cbp_pkg::CH_CR) begin
            ctl_o.phase = cbp_pkg::PH_LEN_LF;
          end else begin
            result_o.status = cbp_pkg::ST_BAD;
          end
        end
        cbp_pkg::PH_LEN_LF: begin
          if (byte_i == cbp_pkg::CH_LF && ctl_i.have_digit) begin
            chunk_size_o     = len_accum_i;
            bytes_seen_o     = '0;
            len_accum_o      = '0;
            ctl_o.have_digit = 1'b0;
            ctl_o.phase      = cbp_pkg::PH_DATA;
          end else begin
            result_o.status = cbp_pkg::ST_BAD;
          end
        end
        cbp_pkg::PH_DATA: begin
          // The count advances on every byte of this phase, good or bad, and saturates at its maximum.
          bytes_seen_o = seen_inc;
          if (take) begin
            result_o.data_valid = 1'b1;
            result_o.out_byte   = byte_i;
          end else if (byte_i == cbp_pkg::CH_CR) begin
            ctl_o.phase = cbp_pkg::PH_DATA_LF;
          end else begin
            result_o.status = cbp_pkg::ST_BAD;
          end
        end
        cbp_pkg::PH_DATA_LF: begin
          if (byte_i == cbp_pkg::CH_LF) begin
            if (chunk_size_i == '0) begin
              result_o.status = cbp_pkg::ST_DONE;
            end else begin
              ctl_o.phase = cbp_pkg::PH_LEN;
            end
          end else begin
            result_o.status = cbp_pkg::ST_BAD;
          end
        end
        default: begin
          result_o.status = cbp_pkg::ST_BAD;
        end
      endcase
    end
  end

endmodule

@@ src/chunked_body_parser.sv @@
// Top level of the chunked body parser: input register, parse state, result register.
//
// The parser takes a chunked message body one byte per item and returns one
// result item per byte. Chunk lengths are written in decimal digits, ended by
// CR LF; exactly that many payload bytes follow, then CR LF. Payload bytes come
// out with the data-valid flag set. The status is pending, done (after the CR LF
// of a zero-length chunk, and again for every further LF) or error; a wrong byte,
// an empty length or a length past 2^LENGTH_WIDTH-1 reports an error and leaves
// the phase unchanged. Chunk extensions and trailers are not accepted. Setting
// the restart flag of an item returns the parser to the length phase with all
// counters cleared; its byte is ignored and its result is pending with no data.
// The block takes one item every cycle while back-pressure does not stall it: an
// item is held in the input register, is parsed by the combinational step logic
// (a multiply by ten four bits wider than the length and a length-wide compare
// set its depth) and is then registered in the result register, from which its
// result is offered. Both registers advance together, so back-pressure on the
// result side stalls the input side only when both registers are full.
module chunked_body_parser #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] status, [9:2] out_byte, rest zero
  output logic        m_axis_tuser_o    // [0] data_valid
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  cbp_pkg::result_t out_res_q;

  // Parse state.
  cbp_pkg::ctl_t           ctl_q, ctl_d;
  logic [LENGTH_WIDTH-1:0] len_accum_q, len_accum_d;
  logic [LENGTH_WIDTH-1:0] chunk_size_q, chunk_size_d;
  logic [LENGTH_WIDTH-1:0] bytes_seen_q, bytes_seen_d;
  cbp_pkg::result_t        step_res;

  logic advance;
  logic in_take;

  // The held item moves into the result register when that register is empty
  // or is being emptied in this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  cbp_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .byte_i      (in_byte_q),
    .restart_i   (in_restart_q),
    .ctl_i       (ctl_q),
    .len_accum_i (len_accum_q),
    .chunk_size_i(chunk_size_q),
    .bytes_seen_i(bytes_seen_q),
    .ctl_o       (ctl_d),
    .len_accum_o (len_accum_d),
    .chunk_size_o(chunk_size_d),
    .bytes_seen_o(bytes_seen_d),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      ctl_q.phase  <= cbp_pkg::PH_LEN;
      ctl_q.have_digit <= 1'b0;
      len_accum_q  <= '0;
      chunk_size_q <= '0;
      bytes_seen_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // The parse state moves only when an item is parsed.
      if (advance) begin
        ctl_q        <= ctl_d;
        len_accum_q  <= len_accum_d;
        chunk_size_q <= chunk_size_d;
        bytes_seen_q <= bytes_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_res_q.out_byte, out_res_q.status};
  assign m_axis_tuser_o  = out_res_q.data_valid;

  // A payload byte never comes with a done or error status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.data_valid |-> out_res_q.status == cbp_pkg::ST_PENDING)
    else $error("payload byte reported with non-pending status");

  // A parsed restart leaves the parser in the length phase with cleared counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_restart_q |=> ctl_q.phase == cbp_pkg::PH_LEN && !ctl_q.have_digit &&
      len_accum_q == '0 && chunk_size_q == '0 && bytes_seen_q == '0)
    else $error("restart did not clear the parse state");

  // The parse state holds while no item is parsed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ctl_q) && $stable(len_accum_q) && $stable(bytes_seen_q) &&
      $stable(chunk_size_q))
    else $error("parse state changed without an item");

  // The payload count only moves in the payload phase, in the length LF phase (where it is cleared) or on restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_restart_q && ctl_q.phase != cbp_pkg::PH_DATA &&
      ctl_q.phase != cbp_pkg::PH_LEN_LF |=> $stable(bytes_seen_q))
    else $error("payload count moved outside the payload phase");

endmodule
